[rtl/icpc_pkg.sv]
`default_nettype none

package icpc_pkg;

  // Chunk identifiers and FORM types, big-endian ASCII
  localparam logic [31:0] ID_FORM = 32'h464f524d;  // "FORM"
  localparam logic [31:0] ID_DJVU = 32'h444a5655;  // "DJVU"
  localparam logic [31:0] ID_DJVM = 32'h444a564d;  // "DJVM"
  localparam logic [31:0] ID_ATT  = 32'h41542654;  // "AT&T"

  // Status codes given with the result
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_DEEP  = 2'd2;

  typedef enum logic [1:0] {
    PH_ID,
    PH_LEN,
    PH_TYPE,
    PH_SKIP
  } phase_t;

endpackage

`default_nettype wire

[rtl/icpc_if.sv]
`default_nettype none

interface icpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface icpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pages_found;
  logic [1:0]  status_code;

  modport source (output valid, output pages_found, output status_code, input ready);
  modport sink (input valid, input pages_found, input status_code, output ready);
endinterface

`default_nettype wire

[rtl/iff_chunk_page_counter_core.sv]
// Chunk walker that counts DjVu pages in a container file.
// byte_in carries one file byte per handshake: data_byte in offset order and
// last_byte high on the final byte. Nothing comes out until the final byte;
// then result_out carries a single word with pages_found (saturating) and
// status_code (0 ok, 1 file ended inside a header or an open FORM, 2 nesting
// deeper than MAX_NEST).
// Throughput: one byte per cycle. Each byte goes through one pass of logic
// (header shift, saturating offset add, a parallel compare of the region
// end stack against the new offset) straight into the state registers.
// Latency: the result word is valid in the cycle after the final byte is
// taken, held in an output register.
// Stall: while the result waits, further bytes are still taken; only a new
// final byte is held off (ready low) until the waiting result is taken.
// Reset (rst, synchronous): clears all control state and drops any pending
// result. After each result the walker returns to its reset state, so the
// next byte starts a new file. The region stack needs no clearing: only
// entries below the current depth are ever compared in a useful way.
`default_nettype none

module iff_chunk_page_counter_core #(
  parameter int MAX_NEST    = 8,
  parameter int OFFSET_BITS = 32,
  parameter int COUNT_BITS  = 16
) (
  input  wire         clk,
  input  wire         rst,
  icpc_in_if.sink     byte_in,
  icpc_out_if.source  result_out
);

  localparam int DEP_W = $clog2(MAX_NEST + 1);
  localparam int IDX_W = $clog2(MAX_NEST);
  localparam int SUM_W = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 1;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [COUNT_BITS-1:0]  CNT_MAX = '1;
  localparam logic [DEP_W-1:0]       NEST_LIM = DEP_W'(MAX_NEST);

  // Walker state
  logic [OFFSET_BITS-1:0] byte_position;
  icpc_pkg::phase_t       parse_phase;
  logic [31:0]            header_shift;
  logic [1:0]             header_byte_count;
  logic [31:0]            held_chunk_id;
  logic [OFFSET_BITS-1:0] region_end_stack [MAX_NEST];
  logic [DEP_W-1:0]       stack_depth;
  logic [OFFSET_BITS-1:0] skip_until;
  logic [COUNT_BITS-1:0]  page_total;
  logic [1:0]             error_latch;

  // Result register
  logic        res_valid;
  logic [15:0] res_pages;
  logic [1:0]  res_status;

  logic accept;

  // Next values
  logic [OFFSET_BITS-1:0] byte_position_next;
  icpc_pkg::phase_t       parse_phase_next;
  logic [31:0]            header_shift_next;
  logic [1:0]             header_byte_count_next;
  logic [31:0]            held_chunk_id_next;
  logic [DEP_W-1:0]       stack_depth_next;
  logic [OFFSET_BITS-1:0] skip_until_next;
  logic [COUNT_BITS-1:0]  page_total_next;
  logic [1:0]             error_latch_next;
  logic [1:0]             status_next;

  logic                   word_done;
  logic                   boundary;
  logic                   push;
  logic [DEP_W-1:0]       depth_pushed;
  logic [OFFSET_BITS-1:0] stack_view [MAX_NEST];
  logic [MAX_NEST-1:0]    ge_pos;
  logic [MAX_NEST-1:0]    ge_skip;
  logic [SUM_W-1:0]       len_sum;
  logic [OFFSET_BITS-1:0] chunk_end;
  logic [OFFSET_BITS-1:0] skip_raw;
  logic [OFFSET_BITS-1:0] skip_even;
  logic                   trunc;
  logic [DEP_W-1:0]       depth_at_eof;

  // Close regions from the top of the stack while their end has been reached:
  // the new depth sits just above the highest open entry that has not ended.
  function automatic logic [DEP_W-1:0] pop_depth(input logic [MAX_NEST-1:0] ge,
                                                 input logic [DEP_W-1:0] d);
    logic [DEP_W-1:0] nd;
    nd = '0;
    for (int i = 0; i < MAX_NEST; i++) begin
      if (DEP_W'(i) < d && !ge[i]) nd = DEP_W'(i + 1);
    end
    return nd;
  endfunction

  // Take a byte unless it would make a second result while one still waits
  assign byte_in.ready = !res_valid || result_out.ready || !byte_in.last_byte;
  assign accept        = byte_in.valid && byte_in.ready;

  assign result_out.valid       = res_valid;
  assign result_out.pages_found = res_pages;
  assign result_out.status_code = res_status;

  // Saturating offset arithmetic; the length is the word just shifted in
  assign byte_position_next = (byte_position == OFF_MAX) ? byte_position
                                                         : byte_position + 1'b1;
  assign len_sum   = SUM_W'(byte_position_next) +
                     SUM_W'({header_shift[23:0], byte_in.data_byte});
  assign chunk_end = (len_sum > SUM_W'(OFF_MAX)) ? OFF_MAX
                                                 : len_sum[OFFSET_BITS-1:0];
  // One pad-to-even unit serves both the plain chunk and the skipped FORM
  assign skip_raw  = (parse_phase == icpc_pkg::PH_LEN) ? chunk_end : skip_until;
  assign skip_even = (skip_raw[0] && skip_raw != OFF_MAX) ? skip_raw + 1'b1
                                                          : skip_raw;

  always_comb begin
    parse_phase_next       = parse_phase;
    header_shift_next      = header_shift;
    header_byte_count_next = header_byte_count;
    held_chunk_id_next     = held_chunk_id;
    skip_until_next        = skip_until;
    page_total_next        = page_total;
    error_latch_next       = error_latch;
    word_done              = 1'b0;
    boundary               = 1'b0;
    push                   = 1'b0;

    // Gather header bytes outside a skip
    if (parse_phase != icpc_pkg::PH_SKIP) begin
      header_shift_next      = {header_shift[23:0], byte_in.data_byte};
      word_done              = (header_byte_count == 2'd3);
      header_byte_count_next = header_byte_count + 2'd1;
    end

    unique case (parse_phase)
      icpc_pkg::PH_SKIP: begin
        if (byte_position_next >= skip_until) boundary = 1'b1;
      end
      icpc_pkg::PH_ID: begin
        if (word_done) begin
          held_chunk_id_next = header_shift_next;
          if (header_shift_next == icpc_pkg::ID_ATT) boundary = 1'b1;
          else parse_phase_next = icpc_pkg::PH_LEN;
        end
      end
      icpc_pkg::PH_LEN: begin
        if (word_done) begin
          if (held_chunk_id == icpc_pkg::ID_FORM) begin
            // Hold the FORM end while its type is read
            skip_until_next  = chunk_end;
            parse_phase_next = icpc_pkg::PH_TYPE;
          end else begin
            skip_until_next = skip_even;
            if (byte_position_next >= skip_even) boundary = 1'b1;
            else parse_phase_next = icpc_pkg::PH_SKIP;
          end
        end
      end
      icpc_pkg::PH_TYPE: begin
        if (word_done) begin
          if (header_shift_next == icpc_pkg::ID_DJVU && page_total != CNT_MAX)
            page_total_next = page_total + 1'b1;
          if ((header_shift_next == icpc_pkg::ID_DJVU ||
               header_shift_next == icpc_pkg::ID_DJVM) && stack_depth < NEST_LIM) begin
            // Descend: open a region ending at the FORM end
            push     = 1'b1;
            boundary = 1'b1;
          end else begin
            if ((header_shift_next == icpc_pkg::ID_DJVU ||
                 header_shift_next == icpc_pkg::ID_DJVM) &&
                error_latch == icpc_pkg::ST_OK)
              error_latch_next = icpc_pkg::ST_DEEP;
            skip_until_next = skip_even;
            if (byte_position_next >= skip_even) boundary = 1'b1;
            else parse_phase_next = icpc_pkg::PH_SKIP;
          end
        end
      end
      default: ;
    endcase

    if (boundary) begin
      parse_phase_next       = icpc_pkg::PH_ID;
      header_byte_count_next = 2'd0;
      header_shift_next      = '0;
    end
  end

  // Stack as it stands after this byte's push
  assign depth_pushed = push ? stack_depth + 1'b1 : stack_depth;

  always_comb begin
    for (int i = 0; i < MAX_NEST; i++) begin
      stack_view[i] = (push && stack_depth[IDX_W-1:0] == IDX_W'(i)) ? skip_until
                                                                   : region_end_stack[i];
      ge_pos[i]  = byte_position_next >= stack_view[i];
      ge_skip[i] = skip_until_next >= stack_view[i];
    end
  end

  assign stack_depth_next = boundary ? pop_depth(ge_pos, depth_pushed) : depth_pushed;

  // End of file: a skip ends where it ends; any region open past it is cut short
  assign depth_at_eof = pop_depth(ge_skip, stack_depth_next);

  always_comb begin
    if (parse_phase_next == icpc_pkg::PH_SKIP)
      trunc = (depth_at_eof != '0);
    else if (parse_phase_next != icpc_pkg::PH_ID || header_byte_count_next != 2'd0)
      trunc = 1'b1;
    else
      trunc = (stack_depth_next != '0);

    if (error_latch_next != icpc_pkg::ST_OK) status_next = error_latch_next;
    else if (trunc) status_next = icpc_pkg::ST_TRUNC;
    else status_next = icpc_pkg::ST_OK;
  end

  // Control state; return to reset after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      parse_phase       <= icpc_pkg::PH_ID;
      header_shift      <= '0;
      header_byte_count <= 2'd0;
      held_chunk_id     <= '0;
      stack_depth       <= '0;
      skip_until        <= '0;
      page_total        <= '0;
      error_latch       <= icpc_pkg::ST_OK;
    end else if (accept) begin
      if (byte_in.last_byte) begin
        byte_position     <= '0;
        parse_phase       <= icpc_pkg::PH_ID;
        header_shift      <= '0;
        header_byte_count <= 2'd0;
        held_chunk_id     <= '0;
        stack_depth       <= '0;
        skip_until        <= '0;
        page_total        <= '0;
        error_latch       <= icpc_pkg::ST_OK;
      end else begin
        byte_position     <= byte_position_next;
        parse_phase       <= parse_phase_next;
        header_shift      <= header_shift_next;
        header_byte_count <= header_byte_count_next;
        held_chunk_id     <= held_chunk_id_next;
        stack_depth       <= stack_depth_next;
        skip_until        <= skip_until_next;
        page_total        <= page_total_next;
        error_latch       <= error_latch_next;
      end
    end
  end

  // Region end stack: written at the current depth, no reset
  always_ff @(posedge clk) begin
    if (accept && push) region_end_stack[stack_depth[IDX_W-1:0]] <= skip_until;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && byte_in.last_byte) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_in.last_byte) begin
      res_pages  <= 16'(page_total_next);
      res_status <= status_next;
    end
  end

endmodule

`default_nettype wire
